// ===== hdl/esbp_pkg.sv =====
// Shared codes, widths and defaults for the exact-size buffer pool.
package esbp_pkg;

  // Operation codes carried in the input word's tuser
  localparam logic [1:0] FUNC_ACQUIRE = 2'd0;
  localparam logic [1:0] FUNC_RELEASE = 2'd1;
  localparam logic [1:0] FUNC_DELETE  = 2'd2;
  localparam logic [1:0] FUNC_UNDEF   = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TRANSIENT = 2'd1;
  localparam logic [1:0] ST_FAIL      = 2'd2;

  // Field widths
  localparam int SIZE_W  = 40;
  localparam int LGEN_W  = 32;
  localparam int LSLOT_W = 4;
  localparam int LIMIT_W = 5;
  localparam int COUNT_W = 5;

  // Port widths (packed fields padded to whole bytes)
  localparam int IN_DATA_W  = 120;
  localparam int OUT_DATA_W = 48;

  // Defaults
  localparam int DEF_SLOT_DEPTH     = 16;
  localparam int DEF_MAX_TRANSIENTS = 16;
  localparam int DEF_STAMP_WIDTH    = 32;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

endpackage

// ===== hdl/exact_size_buffer_pool_unit.sv =====
// Exact-size buffer pool: slot table and transient lease table held in memories.
// Acquire and delete-all scan the present slots, one slot read per cycle, then decide;
// a pooled release reads and checks its slot; a rejected word goes straight to output.
// Transient release searches entries in order and, on a hit, shifts the later ones down.
// One word at a time; the next is taken while a result waits in the output register.
// Reset (rst_n low, synchronous) empties both tables, zeroes stamps, sets the limit to 16.
module exact_size_buffer_pool_unit #(
  parameter int SLOT_DEPTH     = esbp_pkg::DEF_SLOT_DEPTH,
  parameter int MAX_TRANSIENTS = esbp_pkg::DEF_MAX_TRANSIENTS,
  parameter int STAMP_WIDTH    = esbp_pkg::DEF_STAMP_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input: [39:0] req_size, [40] create_ok, [44:41] lease_slot, [45] lease_transient,
  //        [77:46] lease_generation, [117:78] lease_size
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [esbp_pkg::IN_DATA_W-1:0]    in_tdata,
  input  logic [1:0]                        in_tuser,   // [1:0] func
  // output: [3:0] out_slot, [35:4] out_generation, [36] create_request,
  //         [37] destroy_request, [42:38] slot_count
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [esbp_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic [1:0]                        out_tuser,  // [1:0] status
  input  logic                              cfg_we,
  input  logic [esbp_pkg::LIMIT_W-1:0]      cfg_wdata
);

  localparam int SW  = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
  localparam int CW  = $clog2(SLOT_DEPTH + 1);
  localparam int TIW = (MAX_TRANSIENTS > 1) ? $clog2(MAX_TRANSIENTS) : 1;
  localparam int TCW = $clog2(MAX_TRANSIENTS + 1);
  localparam int ST  = STAMP_WIDTH;
  localparam int GW  = (STAMP_WIDTH > 32) ? STAMP_WIDTH : 32;

  typedef struct packed {
    logic                          in_use;
    logic                          has_buf;
    logic [esbp_pkg::SIZE_W-1:0]   size;
    logic [ST-1:0]                 gen;
    logic [ST-1:0]                 last;
  } entry_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_DEC, S_RREAD, S_RCHK,
    S_TSRD, S_TSCMP, S_TSHRD, S_TSHWR, S_TFIN, S_OUT
  } state_t;

  state_t st_r;
  state_t start_st;

  // Latched word
  logic [1:0]                    op_r;
  logic [esbp_pkg::SIZE_W-1:0]   req_r;
  logic                          ok_r;
  logic [esbp_pkg::LSLOT_W-1:0]  lslot_r;
  logic [esbp_pkg::LGEN_W-1:0]   lgen_r;
  logic [esbp_pkg::SIZE_W-1:0]   lsize_r;

  // Pool state
  logic [esbp_pkg::LIMIT_W-1:0]  limit_r;
  logic [CW-1:0]                 present_r;
  logic [ST-1:0]                 seq_r;
  logic [TCW-1:0]                tcnt_r;

  // Scan bookkeeping
  logic [CW-1:0]                 rd_idx_r;
  logic [SW-1:0]                 idx_d_r;
  logic                          pend_r;
  logic                          m_found_r;
  logic [SW-1:0]                 m_idx_r;
  logic                          m_hasbuf_r;
  logic                          o_found_r;
  logic [SW-1:0]                 o_idx_r;
  logic                          o_hasbuf_r;
  logic [ST-1:0]                 oldest_r;
  logic                          any_use_r;
  logic                          any_buf_r;
  logic [TCW-1:0]                tj_r;

  // Result being built and output register
  logic [1:0]                    res_status_r;
  logic [SW-1:0]                 res_slot_r;
  logic [ST-1:0]                 res_gen_r;
  logic                          res_create_r;
  logic                          res_destroy_r;
  logic                          out_valid_r;
  logic [esbp_pkg::OUT_DATA_W-1:0] out_data_r;
  logic [1:0]                    out_user_r;
  logic                          out_load;

  // Memories
  entry_t                        slot_mem [SLOT_DEPTH];
  entry_t                        sm_rdata;
  logic                          sm_re, sm_we;
  logic [SW-1:0]                 sm_raddr, sm_waddr;
  entry_t                        sm_wdata;
  logic [ST-1:0]                 tr_mem [MAX_TRANSIENTS];
  logic [ST-1:0]                 tm_rdata;
  logic                          tm_re, tm_we;
  logic [TIW-1:0]                tm_raddr, tm_waddr;
  logic [ST-1:0]                 tm_wdata;

  logic [ST-1:0]                 stamp_nxt;
  logic                          can_append;
  logic                          rel_ok;
  logic                          tr_full;
  entry_t                        new_ent;

  assign stamp_nxt  = seq_r + ST'(1);
  assign can_append = (32'(present_r) < 32'(limit_r)) && (32'(present_r) < 32'(SLOT_DEPTH));
  assign rel_ok     = sm_rdata.in_use && (GW'(sm_rdata.gen) == GW'(lgen_r)) &&
                      (sm_rdata.size == lsize_r);
  assign tr_full    = (32'(tcnt_r) >= 32'(MAX_TRANSIENTS));
  assign new_ent    = '{in_use: 1'b1, has_buf: 1'b1, size: req_r,
                        gen: stamp_nxt, last: stamp_nxt};

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_load   = (st_r == S_OUT) && (!out_valid_r || out_tready);

  // First state for a newly taken word
  always_comb begin
    start_st = S_OUT;
    case (in_tuser)
      esbp_pkg::FUNC_ACQUIRE: begin
        if (in_tdata[39:0] != '0) start_st = S_SCAN;
      end
      esbp_pkg::FUNC_RELEASE: begin
        if (in_tdata[77:46] != '0) begin
          if (!in_tdata[45]) begin
            if (32'(in_tdata[44:41]) < 32'(present_r)) start_st = S_RREAD;
          end else if (tcnt_r != '0) begin
            start_st = S_TSRD;
          end
        end
      end
      esbp_pkg::FUNC_DELETE: begin
        if (tcnt_r == '0) start_st = S_SCAN;
      end
      default: ;
    endcase
  end

  // Memory port control
  always_comb begin
    sm_re    = 1'b0;
    sm_raddr = '0;
    sm_we    = 1'b0;
    sm_waddr = '0;
    sm_wdata = '0;
    tm_re    = 1'b0;
    tm_raddr = '0;
    tm_we    = 1'b0;
    tm_waddr = '0;
    tm_wdata = '0;
    case (st_r)
      S_SCAN: begin
        if (rd_idx_r < present_r) begin
          sm_re    = 1'b1;
          sm_raddr = rd_idx_r[SW-1:0];
        end
      end
      S_RREAD: begin
        sm_re    = 1'b1;
        sm_raddr = SW'(lslot_r);
      end
      S_RCHK: begin
        if (rel_ok) begin
          sm_we    = 1'b1;
          sm_waddr = SW'(lslot_r);
          sm_wdata = sm_rdata;
          sm_wdata.in_use = 1'b0;
          sm_wdata.last   = stamp_nxt;
        end
      end
      S_DEC: begin
        if (op_r == esbp_pkg::FUNC_ACQUIRE) begin
          if (m_found_r) begin
            sm_we    = 1'b1;
            sm_waddr = m_idx_r;
            sm_wdata = new_ent;
            sm_wdata.has_buf = m_hasbuf_r;
          end else if (can_append) begin
            sm_we    = 1'b1;
            sm_waddr = present_r[SW-1:0];
            sm_wdata = ok_r ? new_ent : '0;
          end else if (o_found_r) begin
            sm_we    = 1'b1;
            sm_waddr = o_idx_r;
            sm_wdata = ok_r ? new_ent : '0;
          end else if (!tr_full && ok_r) begin
            tm_we    = 1'b1;
            tm_waddr = tcnt_r[TIW-1:0];
            tm_wdata = stamp_nxt;
          end
        end
      end
      S_TSRD: begin
        tm_re    = 1'b1;
        tm_raddr = tj_r[TIW-1:0];
      end
      S_TSHRD: begin
        tm_re    = 1'b1;
        tm_raddr = TIW'(tj_r + TCW'(1));
      end
      S_TSHWR: begin
        tm_we    = 1'b1;
        tm_waddr = tj_r[TIW-1:0];
        tm_wdata = tm_rdata;
      end
      default: ;
    endcase
  end

  // Slot memory
  always_ff @(posedge clk) begin
    if (sm_we) slot_mem[sm_waddr] <= sm_wdata;
    if (sm_re) sm_rdata <= slot_mem[sm_raddr];
  end

  // Transient generation memory
  always_ff @(posedge clk) begin
    if (tm_we) tr_mem[tm_waddr] <= tm_wdata;
    if (tm_re) tm_rdata <= tr_mem[tm_raddr];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      limit_r     <= esbp_pkg::LIMIT_RESET;
      present_r   <= '0;
      seq_r       <= '0;
      tcnt_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) limit_r <= cfg_wdata;
      if (out_load) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;

      unique case (st_r)
        S_IDLE: begin
          if (in_tvalid) begin
            op_r          <= in_tuser;
            req_r         <= in_tdata[39:0];
            ok_r          <= in_tdata[40];
            lslot_r       <= in_tdata[44:41];
            lgen_r        <= in_tdata[77:46];
            lsize_r       <= in_tdata[117:78];
            res_status_r  <= esbp_pkg::ST_FAIL;
            res_slot_r    <= '0;
            res_gen_r     <= '0;
            res_create_r  <= 1'b0;
            res_destroy_r <= 1'b0;
            rd_idx_r      <= '0;
            pend_r        <= 1'b0;
            m_found_r     <= 1'b0;
            o_found_r     <= 1'b0;
            oldest_r      <= '1;
            any_use_r     <= 1'b0;
            any_buf_r     <= 1'b0;
            tj_r          <= '0;
            st_r          <= start_st;
          end
        end

        // One slot read issued per cycle; the previous one is examined
        S_SCAN: begin
          if (rd_idx_r < present_r) begin
            idx_d_r  <= rd_idx_r[SW-1:0];
            rd_idx_r <= rd_idx_r + CW'(1);
            pend_r   <= 1'b1;
          end else begin
            pend_r <= 1'b0;
            if (!pend_r) st_r <= S_DEC;
          end
          if (pend_r) begin
            any_use_r <= any_use_r | sm_rdata.in_use;
            any_buf_r <= any_buf_r | sm_rdata.has_buf;
            if (!sm_rdata.in_use && (sm_rdata.size == req_r) && !m_found_r) begin
              m_found_r  <= 1'b1;
              m_idx_r    <= idx_d_r;
              m_hasbuf_r <= sm_rdata.has_buf;
            end
            // first idle slot always qualifies, later ones only with an older stamp
            if (!sm_rdata.in_use && (!o_found_r || (sm_rdata.last < oldest_r))) begin
              oldest_r   <= sm_rdata.last;
              o_found_r  <= 1'b1;
              o_idx_r    <= idx_d_r;
              o_hasbuf_r <= sm_rdata.has_buf;
            end
          end
        end

        S_DEC: begin
          st_r <= S_OUT;
          if (op_r == esbp_pkg::FUNC_ACQUIRE) begin
            if (m_found_r) begin
              seq_r        <= stamp_nxt;
              res_status_r <= esbp_pkg::ST_OK;
              res_slot_r   <= m_idx_r;
              res_gen_r    <= stamp_nxt;
            end else if (can_append || o_found_r) begin
              res_create_r  <= 1'b1;
              res_destroy_r <= !can_append && o_hasbuf_r;
              if (can_append) present_r <= present_r + CW'(1);
              if (ok_r) begin
                seq_r        <= stamp_nxt;
                res_status_r <= esbp_pkg::ST_OK;
                res_slot_r   <= can_append ? present_r[SW-1:0] : o_idx_r;
                res_gen_r    <= stamp_nxt;
              end
            end else if (!tr_full) begin
              res_create_r <= 1'b1;
              if (ok_r) begin
                seq_r        <= stamp_nxt;
                tcnt_r       <= tcnt_r + TCW'(1);
                res_status_r <= esbp_pkg::ST_TRANSIENT;
                res_gen_r    <= stamp_nxt;
              end
            end
          end else if (!any_use_r) begin
            // delete-all with nothing leased
            res_status_r  <= esbp_pkg::ST_OK;
            res_destroy_r <= any_buf_r;
            present_r     <= '0;
          end
        end

        S_RREAD: st_r <= S_RCHK;

        S_RCHK: begin
          if (rel_ok) begin
            seq_r        <= stamp_nxt;
            res_status_r <= esbp_pkg::ST_OK;
          end
          st_r <= S_OUT;
        end

        S_TSRD: st_r <= S_TSCMP;

        // Compare one transient; on a hit, shift the tail down over it
        S_TSCMP: begin
          if (GW'(tm_rdata) == GW'(lgen_r)) begin
            if (32'(tj_r) + 32'd1 < 32'(tcnt_r)) st_r <= S_TSHRD;
            else st_r <= S_TFIN;
          end else if (32'(tj_r) + 32'd1 < 32'(tcnt_r)) begin
            tj_r <= tj_r + TCW'(1);
            st_r <= S_TSRD;
          end else begin
            st_r <= S_OUT;
          end
        end

        S_TSHRD: st_r <= S_TSHWR;

        S_TSHWR: begin
          if (32'(tj_r) + 32'd2 < 32'(tcnt_r)) begin
            tj_r <= tj_r + TCW'(1);
            st_r <= S_TSHRD;
          end else begin
            st_r <= S_TFIN;
          end
        end

        S_TFIN: begin
          tcnt_r        <= tcnt_r - TCW'(1);
          res_status_r  <= esbp_pkg::ST_OK;
          res_destroy_r <= 1'b1;
          st_r          <= S_OUT;
        end

        // Hand the result to the output register once it is free
        S_OUT: begin
          if (out_load) begin
            out_user_r  <= res_status_r;
            out_data_r  <= {5'b0, esbp_pkg::COUNT_W'(present_r), res_destroy_r,
                            res_create_r, 32'(res_gen_r), 4'(res_slot_r)};
            st_r        <= S_IDLE;
          end
        end

        default: st_r <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_present_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(present_r) <= 32'(SLOT_DEPTH))
    else $error("slot count beyond table depth");

  a_tcnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(tcnt_r) <= 32'(MAX_TRANSIENTS))
    else $error("transient count beyond table depth");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_IDLE) |-> (!sm_we && !tm_we))
    else $error("memory written while idle");

  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r == S_OUT))
    else $error("result word raised outside the output state");

  a_present_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (present_r != $past(present_r)) |-> ($past(st_r == S_DEC)))
    else $error("slot count changed outside a decision");

endmodule
